// ===== hdl/dvc_pkg.sv =====
// shared types, codes and sizes for the sliding window distinct counter
package dvc_pkg;

  localparam int POSITIONS_DEF = 1024;
  localparam int VALUES_DEF    = 1024;
  localparam int FIELD_W       = 10;
  localparam int CNT_W         = 11;
  localparam int LEN_W         = 11;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_RANGE   = 2'd1;
  localparam logic [1:0] ST_LOAD_REJECT = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_FETCH,
    S_UPDATE,
    S_EMIT
  } dvc_state_t;

  typedef struct packed {
    logic rd;
    logic upd;
    logic enter;
  } occ_cmd_t;

endpackage

// ===== hdl/dvc_occ_table.sv =====
// occurrence table memory with read-modify-write update, distinct total and clearing sweep
module dvc_occ_table import dvc_pkg::*; #(
  parameter int VALUES = VALUES_DEF,
  localparam int VW = (VALUES > 1) ? $clog2(VALUES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  occ_cmd_t         cmd,
  input  logic [VW-1:0]    addr,
  output logic [CNT_W-1:0] total,
  output logic             busy
);

  logic [CNT_W-1:0] mem [VALUES];
  logic [CNT_W-1:0] q_r;
  logic [VW-1:0]    addr_r;
  logic [VW-1:0]    clr_r;
  logic [VW-1:0]    clr_nxt;
  logic             clearing_r;
  logic             clearing_nxt;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;

  assign total = total_r;
  assign busy  = clearing_r;

  always_comb begin
    cnt_new      = cmd.enter ? q_r + 1'b1 : q_r - 1'b1;
    total_nxt    = total_r;
    clr_nxt      = clr_r;
    clearing_nxt = clearing_r;
    if (cmd.upd) begin
      if (cmd.enter && cnt_new == CNT_W'(1)) begin
        total_nxt = total_r + 1'b1;
      end else if (!cmd.enter && cnt_new == '0) begin
        total_nxt = total_r - 1'b1;
      end
    end
    if (clearing_r) begin
      if (clr_r == VW'(VALUES - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_nxt = clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
      total_r    <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_r      <= clr_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      q_r    <= mem[addr];
      addr_r <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= '0;
    end else if (cmd.upd) begin
      mem[addr_r] <= cnt_new;
    end
  end

endmodule

// ===== hdl/sliding_window_distinct_counter.sv =====
// top level: value store, window sequencer and result register of the distinct counter
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+--------------------
//  in      | opcode, load_position, load_value, range_low/high  | in_valid / in_stall
//  out     | distinct_values, status                            | out_valid / out_stall
//
// a load in bounds and outside the window is written with no result; a rejected load or bad
// range waits in the emit state for the output; a query makes window edge steps (value store
// read, occurrence read, occurrence write back), as many as the distance between windows
// after reset the occurrence table is swept to zero with in_stall high
// a waiting result holds the sequencer in its emit state until out_stall drops
module sliding_window_distinct_counter import dvc_pkg::*; #(
  parameter int POSITIONS = POSITIONS_DEF,
  parameter int VALUES    = VALUES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [FIELD_W-1:0] in_load_position,
  input  logic [FIELD_W-1:0] in_load_value,
  input  logic [FIELD_W-1:0] in_range_low,
  input  logic [FIELD_W-1:0] in_range_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CNT_W-1:0]   out_distinct_values,
  output logic [1:0]         out_status
);

  localparam int PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int VW = (VALUES > 1) ? $clog2(VALUES) : 1;

  dvc_state_t state_r, state_nxt;

  logic [VW-1:0] vs_mem [POSITIONS];
  logic [VW-1:0] vs_q_r;
  logic          vs_rd;
  logic          vs_we;
  logic [PW-1:0] vs_addr;

  logic [FIELD_W-1:0] wl_r, wl_nxt;
  logic [FIELD_W-1:0] wr_r, wr_nxt;
  logic               wempty_r, wempty_nxt;
  logic [FIELD_W-1:0] lo_r, lo_nxt;
  logic [FIELD_W-1:0] hi_r, hi_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               enter_r, enter_nxt;
  logic [CNT_W-1:0]   res_dist_r, res_dist_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               out_valid_r;
  logic [CNT_W-1:0]   out_dist_r;
  logic [1:0]         out_status_r;

  occ_cmd_t         occ_cmd;
  logic [CNT_W-1:0] occ_total;
  logic             occ_busy;

  logic in_xfer;
  logic out_free;
  logic load_oob;
  logic load_in_win;
  logic query_bad;
  logic step_lgrow;
  logic step_rgrow;
  logic step_lshrink;
  logic step_rshrink;

  assign in_xfer  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign load_oob    = (32'(in_load_position) >= POSITIONS) || (32'(in_load_value) >= VALUES);
  assign load_in_win = !wempty_r && (in_load_position >= wl_r) && (in_load_position <= wr_r);
  assign query_bad   = (in_range_low > in_range_high) ||
                       ({1'b0, in_range_high} >= len_r);

  assign step_lgrow   = wl_r > lo_r;
  assign step_rgrow   = wempty_r || (wr_r < hi_r);
  assign step_lshrink = wl_r < lo_r;
  assign step_rshrink = wr_r > hi_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (!occ_busy) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_LOAD) begin
            if (!load_oob && load_in_win) state_nxt = S_EMIT;
          end else if (query_bad) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (step_lgrow || step_rgrow || step_lshrink || step_rshrink) begin
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_FETCH:  state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_STEP;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall       = (state_r != S_IDLE);
    vs_rd          = 1'b0;
    vs_we          = 1'b0;
    vs_addr        = PW'(wl_r);
    occ_cmd        = '0;
    occ_cmd.enter  = enter_r;
    wl_nxt         = wl_r;
    wr_nxt         = wr_r;
    wempty_nxt     = wempty_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    len_nxt        = len_r;
    enter_nxt      = enter_r;
    res_dist_nxt   = res_dist_r;
    res_status_nxt = res_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_LOAD) begin
            if (!load_oob) begin
              if (load_in_win) begin
                res_dist_nxt   = '0;
                res_status_nxt = ST_LOAD_REJECT;
              end else begin
                vs_we = 1'b1;
                if (LEN_W'(in_load_position) + 1'b1 > len_r) begin
                  len_nxt = LEN_W'(in_load_position) + 1'b1;
                end
              end
            end
          end else if (query_bad) begin
            res_dist_nxt   = '0;
            res_status_nxt = ST_BAD_RANGE;
          end else begin
            lo_nxt = in_range_low;
            hi_nxt = in_range_high;
          end
        end
      end
      S_STEP: begin
        if (step_lgrow) begin
          wl_nxt    = wl_r - 1'b1;
          vs_addr   = PW'(wl_r - 1'b1);
          vs_rd     = 1'b1;
          enter_nxt = 1'b1;
        end else if (step_rgrow) begin
          wr_nxt     = wempty_r ? '0 : wr_r + 1'b1;
          wempty_nxt = 1'b0;
          vs_addr    = wempty_r ? '0 : PW'(wr_r + 1'b1);
          vs_rd      = 1'b1;
          enter_nxt  = 1'b1;
        end else if (step_lshrink) begin
          wl_nxt    = wl_r + 1'b1;
          vs_addr   = PW'(wl_r);
          vs_rd     = 1'b1;
          enter_nxt = 1'b0;
        end else if (step_rshrink) begin
          wr_nxt    = wr_r - 1'b1;
          vs_addr   = PW'(wr_r);
          vs_rd     = 1'b1;
          enter_nxt = 1'b0;
        end else begin
          res_dist_nxt   = occ_total;
          res_status_nxt = ST_OK;
        end
      end
      S_FETCH:  occ_cmd.rd  = 1'b1;
      S_UPDATE: occ_cmd.upd = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      wl_r     <= '0;
      wr_r     <= '0;
      wempty_r <= 1'b1;
      len_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      wl_r     <= wl_nxt;
      wr_r     <= wr_nxt;
      wempty_r <= wempty_nxt;
      len_r    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    enter_r      <= enter_nxt;
    res_dist_r   <= res_dist_nxt;
    res_status_r <= res_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (vs_we) begin
      vs_mem[PW'(in_load_position)] <= VW'(in_load_value);
    end
    if (vs_rd) begin
      vs_q_r <= vs_mem[vs_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_dist_r   <= res_dist_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_distinct_values = out_dist_r;
  assign out_status          = out_status_r;

  dvc_occ_table #(
    .VALUES(VALUES)
  ) u_occ (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (occ_cmd),
    .addr (vs_q_r),
    .total(occ_total),
    .busy (occ_busy)
  );

endmodule

// ===== hdl/dvc_checker.sv =====
// port-level checks for the distinct counter and the bind that attaches them
module dvc_checker import dvc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_opcode,
  input logic [FIELD_W-1:0] in_load_position,
  input logic [FIELD_W-1:0] in_load_value,
  input logic [FIELD_W-1:0] in_range_low,
  input logic [FIELD_W-1:0] in_range_high,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CNT_W-1:0]   out_distinct_values,
  input logic [1:0]         out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distinct_values) && $stable(out_status))
    else $error("stalled result changed");

  // clearing sweep blocks input right after reset
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD_RANGE ||
                   out_status == ST_LOAD_REJECT))
    else $error("unknown status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_distinct_values == '0)
    else $error("error result with nonzero count");

  // a good range is never empty
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_distinct_values != '0)
    else $error("ok result with zero count");

endmodule

bind sliding_window_distinct_counter dvc_checker u_dvc_checker (.*);
